/* design/mce_pkg.sv */
// Package: code word table, character classification and shared types for the Morse encoder
`default_nettype none
package mce_pkg;

    localparam int unsigned WORD_W  = 27;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned TAB_LEN = 44;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam t_idx IDX_LETTER_A = 6'd0;
    localparam t_idx IDX_DIGIT0   = 6'd26;
    localparam t_idx IDX_SPACE    = 6'd36;
    localparam t_idx IDX_LONGSP   = 6'd37;
    localparam t_idx IDX_PERIOD   = 6'd38;
    localparam t_idx IDX_COMMA    = 6'd39;
    localparam t_idx IDX_QUEST    = 6'd40;
    localparam t_idx IDX_SLASH    = 6'd41;
    localparam t_idx IDX_APOS     = 6'd42;
    localparam t_idx IDX_EXCL     = 6'd43;

    localparam t_char CH_SPACE  = 8'd32;
    localparam t_char CH_EXCL   = 8'd33;
    localparam t_char CH_APOS   = 8'd39;
    localparam t_char CH_COMMA  = 8'd44;
    localparam t_char CH_PERIOD = 8'd46;
    localparam t_char CH_SLASH  = 8'd47;
    localparam t_char CH_ZERO   = 8'd48;
    localparam t_char CH_NINE   = 8'd57;
    localparam t_char CH_QUEST  = 8'd63;
    localparam t_char CH_UC_A   = 8'd65;
    localparam t_char CH_UC_Z   = 8'd90;
    localparam t_char CH_LC_A   = 8'd97;
    localparam t_char CH_LC_Z   = 8'd122;

    localparam t_word CODE_TABLE [TAB_LEN] = '{
        27'h000011D, 27'h0001157, 27'h00045D7, 27'h0000457, 27'h0000011,
        27'h0001175, 27'h0001177, 27'h0000455, 27'h0000045, 27'h0011DDD,
        27'h00011D7, 27'h000115D, 27'h0000477, 27'h0000117, 27'h0004777,
        27'h00022DD, 27'h0011D77, 27'h000045D, 27'h0000115, 27'h0000047,
        27'h0000475, 27'h00011D5, 27'h00011DD, 27'h0004757, 27'h0011DD7,
        27'h0004577, 27'h0477777, 27'h011DDDD, 27'h0047775, 27'h0011DD5,
        27'h0004755, 27'h0001155, 27'h0004557, 27'h0011577, 27'h0045777,
        27'h0117777, 27'h0000010, 27'h0000080, 27'h101D75D, 27'h4077577,
        27'h4057751, 27'h0011757, 27'h015DDDD, 27'h04775D7
    };

    function automatic t_idx char_index(input t_char c);
        t_idx idx;
        case (c)
            CH_SPACE:  idx = IDX_SPACE;
            CH_PERIOD: idx = IDX_PERIOD;
            CH_COMMA:  idx = IDX_COMMA;
            CH_QUEST:  idx = IDX_QUEST;
            CH_SLASH:  idx = IDX_SLASH;
            CH_APOS:   idx = IDX_APOS;
            CH_EXCL:   idx = IDX_EXCL;
            default: begin
                if (c inside {[CH_ZERO:CH_NINE]}) begin
                    idx = IDX_W'(c - CH_ZERO) + IDX_DIGIT0;
                end else if (c inside {[CH_LC_A:CH_LC_Z]}) begin
                    idx = IDX_W'(c - CH_LC_A) + IDX_LETTER_A;
                end else if (c inside {[CH_UC_A:CH_UC_Z]}) begin
                    idx = IDX_W'(c - CH_UC_A) + IDX_LETTER_A;
                end else begin
                    idx = IDX_LONGSP;
                end
            end
        endcase
        return idx;
    endfunction

    function automatic t_word code_word(input t_char c);
        t_idx idx;
        idx = char_index(c);
        return CODE_TABLE[idx];
    endfunction

endpackage
`default_nettype wire

/* design/mce_if.sv */
// Interfaces: character input channel and key unit output channel
`default_nettype none
interface mce_char_if;
    logic                  valid;
    logic                  ready;
    logic [7:0]            char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mce_unit_if;
    logic valid;
    logic ready;
    logic key_on;
    logic last_unit;
    modport source (output valid, output key_on, output last_unit, input ready);
    modport sink   (input valid, input key_on, input last_unit, output ready);
endinterface
`default_nettype wire

/* design/mce_front.sv */
// Front end: accept a character, classify it and register its code word
`default_nettype none
module mce_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mce_char_if.sink          i_char,
    output logic              o_push_valid,
    input  wire               i_push_ready,
    output mce_pkg::t_word    o_push_word
);

    logic           r_valid;
    logic           n_valid;
    mce_pkg::t_word r_word;
    mce_pkg::t_word n_word;
    logic           accept;

    assign i_char.ready = !r_valid || i_push_ready;
    assign accept       = i_char.valid && i_char.ready;
    assign o_push_valid = r_valid;
    assign o_push_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        if (accept) begin
            n_valid = 1'b1;
            n_word  = mce_pkg::code_word(i_char.char_code);
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_word <= n_word;
    end

endmodule
`default_nettype wire

/* design/mce_fifo.sv */
// Short code word queue between the front end and the shifter
`default_nettype none
module mce_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  mce_pkg::t_word      i_push_word,
    output logic                o_pop_valid,
    input  wire                 i_pop_ready,
    output mce_pkg::t_word      o_pop_word,
    output mce_pkg::t_q_status  o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mce_pkg::t_word r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_word   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_status     = '{full: !o_push_ready, empty: !o_pop_valid};

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt + CNT_W'(push) - CNT_W'(pop);
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wr] <= i_push_word;
        end
    end

endmodule
`default_nettype wire

/* design/mce_back.sv */
// Back end: shift the code word out one key unit per item into an output register
`default_nettype none
module mce_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_pop_valid,
    output logic              o_pop_ready,
    input  mce_pkg::t_word    i_pop_word,
    mce_unit_if.source        o_unit
);

    localparam int unsigned W = mce_pkg::WORD_W;

    mce_pkg::t_word r_sh;
    mce_pkg::t_word n_sh;
    logic           r_out_valid;
    logic           n_out_valid;
    logic           r_key;
    logic           n_key;
    logic           r_last;
    logic           n_last;
    logic           active;
    logic           last_now;
    logic           emit;

    assign active      = (r_sh[W-1:1] != '0);
    assign last_now    = (r_sh[W-1:2] == '0);
    assign emit        = active && (!r_out_valid || o_unit.ready);
    assign o_pop_ready = !active || (emit && last_now);

    assign o_unit.valid     = r_out_valid;
    assign o_unit.key_on    = r_key;
    assign o_unit.last_unit = r_last;

    always_comb begin
        n_sh        = r_sh;
        n_out_valid = r_out_valid;
        n_key       = r_key;
        n_last      = r_last;
        if (i_pop_valid && o_pop_ready) begin
            n_sh = i_pop_word;
        end else if (emit) begin
            n_sh = {1'b0, r_sh[W-1:1]};
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_key       = r_sh[0];
            n_last      = last_now;
        end else if (o_unit.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sh        <= n_sh;
            r_out_valid <= n_out_valid;
        end
        r_key  <= n_key;
        r_last <= n_last;
    end

endmodule
`default_nettype wire

/* design/morse_char_encoder_core.sv */
// Top level: Morse character encoder, front end, code word queue and shifter
//
// Usage:
//   i_char carries one 8-bit character per item (valid/ready). Lower-case
//   letters are sent as upper case; characters outside the table go out as
//   a long space of seven key-off units.
//   o_unit carries one key unit per item: key_on for a dot or dash unit and
//   last_unit on the final unit of the character, letter gap included.
// Timing:
//   A character yields 4 to 26 units, one per cycle while o_unit is ready.
//   When the block is idle, a taken character's code word passes the front
//   register, the queue, the shifter and the output register before its
//   first unit leaves. The shifter loads the next code word on the cycle of
//   the previous last unit, so characters follow without a gap.
//   i_char stays ready while the queue of DEPTH code words plus the front
//   register have room, so it is taken while earlier units are still going.
// Reset and stall:
//   A synchronous active-low reset empties the queue and drops all pending
//   units. When o_unit is not ready the current unit holds and the shifter
//   waits; the queue fills and then i_char goes not ready.
`default_nettype none
module morse_char_encoder_core #(
    parameter int unsigned DEPTH = 2
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mce_char_if.sink     i_char,
    mce_unit_if.source   o_unit
);

    logic               push_valid;
    logic               push_ready;
    mce_pkg::t_word     push_word;
    logic               pop_valid;
    logic               pop_ready;
    mce_pkg::t_word     pop_word;
    mce_pkg::t_q_status q_status;

    mce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (i_char),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_word  (push_word)
    );

    mce_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_word  (push_word),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_word   (pop_word),
        .o_status     (q_status)
    );

    mce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_word  (pop_word),
        .o_unit      (o_unit)
    );

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    a_word_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid |-> (push_word[mce_pkg::WORD_W-1:1] != '0))
        else $error("code word without any key unit");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_unit.valid)
        else $error("key unit offered right after reset");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !pop_valid)
        else $error("queue offers a word while empty");

endmodule
`default_nettype wire

/* test/morse_unit_checker.sv */
// Checker: predicts the key units of each accepted character and compares them with the output channel
`timescale 1ns / 100ps
module morse_unit_checker (
    input  wire   i_clk,
    input  wire   i_rst_n,
    mce_char_if   i_char_mon,
    mce_unit_if   i_unit_mon,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic           key_on;
        logic           last_unit;
        mce_pkg::t_char src;
    } t_key_unit;

    // key pattern, LSB first, with a marker 1 above the last unit
    localparam bit [26:0] KEY_PATTERNS [44] = '{
        27'h000011D, 27'h0001157, 27'h00045D7, 27'h0000457, 27'h0000011,
        27'h0001175, 27'h0001177, 27'h0000455, 27'h0000045, 27'h0011DDD,
        27'h00011D7, 27'h000115D, 27'h0000477, 27'h0000117, 27'h0004777,
        27'h00022DD, 27'h0011D77, 27'h000045D, 27'h0000115, 27'h0000047,
        27'h0000475, 27'h00011D5, 27'h00011DD, 27'h0004757, 27'h0011DD7,
        27'h0004577, 27'h0477777, 27'h011DDDD, 27'h0047775, 27'h0011DD5,
        27'h0004755, 27'h0001155, 27'h0004557, 27'h0011577, 27'h0045777,
        27'h0117777, 27'h0000010, 27'h0000080, 27'h101D75D, 27'h4077577,
        27'h4057751, 27'h0011757, 27'h015DDDD, 27'h04775D7
    };

    t_key_unit units_due [$];
    int        mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int morse_slot(input mce_pkg::t_char c);
        if (c == mce_pkg::CH_SPACE)  return mce_pkg::IDX_SPACE;
        if (c == mce_pkg::CH_PERIOD) return mce_pkg::IDX_PERIOD;
        if (c == mce_pkg::CH_COMMA)  return mce_pkg::IDX_COMMA;
        if (c == mce_pkg::CH_QUEST)  return mce_pkg::IDX_QUEST;
        if (c == mce_pkg::CH_SLASH)  return mce_pkg::IDX_SLASH;
        if (c == mce_pkg::CH_APOS)   return mce_pkg::IDX_APOS;
        if (c == mce_pkg::CH_EXCL)   return mce_pkg::IDX_EXCL;
        if (c >= mce_pkg::CH_ZERO && c <= mce_pkg::CH_NINE) begin
            return int'(c - mce_pkg::CH_ZERO) + mce_pkg::IDX_DIGIT0;
        end
        // fold lower case onto the letter slots
        if (c >= mce_pkg::CH_LC_A && c <= mce_pkg::CH_LC_Z) return int'(c - mce_pkg::CH_LC_A);
        if (c >= mce_pkg::CH_UC_A && c <= mce_pkg::CH_UC_Z) return int'(c - mce_pkg::CH_UC_A);
        return mce_pkg::IDX_LONGSP;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : watch
        t_key_unit want;
        t_key_unit unit;
        bit [26:0] pattern;
        if (i_rst_n) begin
            if (i_unit_mon.valid && i_unit_mon.ready) begin
                if (units_due.size() == 0) begin
                    report_mismatch($sformatf("key unit on=%0b last=%0b with nothing pending",
                        i_unit_mon.key_on, i_unit_mon.last_unit));
                end else begin
                    want = units_due.pop_front();
                    if (i_unit_mon.key_on !== want.key_on) begin
                        report_mismatch($sformatf("char 0x%02h: key_on %b, want %b",
                            want.src, i_unit_mon.key_on, want.key_on));
                    end
                    if (i_unit_mon.last_unit !== want.last_unit) begin
                        report_mismatch($sformatf("char 0x%02h: last_unit %b, want %b",
                            want.src, i_unit_mon.last_unit, want.last_unit));
                    end
                end
            end
            if (i_char_mon.valid && i_char_mon.ready) begin
                pattern = KEY_PATTERNS[morse_slot(i_char_mon.char_code)];
                while (pattern > 1) begin
                    unit.key_on    = pattern[0];
                    pattern        = pattern >> 1;
                    unit.last_unit = (pattern <= 1);
                    unit.src       = i_char_mon.char_code;
                    units_due.push_back(unit);
                end
            end
        end
        o_pending <= units_due.size();
    end

endmodule

/* test/morse_char_encoder_core_tb.sv */
// Testbench top: clock, reset, character stimulus, output stalls, watchdog and verdict
`timescale 1ns / 100ps
module morse_char_encoder_core_tb;

    localparam int IDLE_LIMIT       = 5000;
    localparam int HOLD_OFF         = 40;
    localparam int RANDOM_PER_PHASE = 107;

    localparam int SEND_IDLE_PCT [4] = '{0, 54, 0, 6};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 54, 6};
    localparam mce_pkg::t_char PUNCT_SET [7] = '{
        mce_pkg::CH_SPACE, mce_pkg::CH_PERIOD, mce_pkg::CH_COMMA, mce_pkg::CH_QUEST,
        mce_pkg::CH_SLASH, mce_pkg::CH_APOS, mce_pkg::CH_EXCL};

    logic           i_clk    = 1'b0;
    logic           i_rst_n  = 1'b0;
    logic           tx_valid = 1'b0;
    mce_pkg::t_char tx_char  = '0;
    logic           rx_ready = 1'b0;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int chars_sent         = 0;
    int units_taken        = 0;
    int quiet_cycles       = 0;
    int fail_count;
    int pending;

    mce_char_if char_ch ();
    mce_unit_if unit_ch ();

    assign char_ch.valid     = tx_valid;
    assign char_ch.char_code = tx_char;
    assign unit_ch.ready     = rx_ready;

    morse_char_encoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch.sink),
        .o_unit  (unit_ch.source)
    );

    morse_unit_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_mon   (char_ch),
        .i_unit_mon   (unit_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        rx_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && char_ch.valid && char_ch.ready) chars_sent <= chars_sent + 1;
        if (i_rst_n && unit_ch.valid && unit_ch.ready) units_taken <= units_taken + 1;
        if (i_rst_n && ((char_ch.valid && char_ch.ready) || (unit_ch.valid && unit_ch.ready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic mce_pkg::t_char pick_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) return mce_pkg::CH_UC_A + mce_pkg::t_char'($urandom_range(25));
        if (roll < 55) return mce_pkg::CH_LC_A + mce_pkg::t_char'($urandom_range(25));
        if (roll < 70) return mce_pkg::CH_ZERO + mce_pkg::t_char'($urandom_range(9));
        if (roll < 82) return PUNCT_SET[$urandom_range(6)];
        return mce_pkg::t_char'($urandom_range(255));
    endfunction

    task automatic send_char(input mce_pkg::t_char c);
        while ($urandom_range(99) < sender_idle_pct) begin
            tx_valid <= 1'b0;
            @(posedge i_clk);
        end
        tx_valid <= 1'b1;
        tx_char  <= c;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
    endtask

    // hold the sender until every predicted unit has left the block
    task automatic drain_units();
        tx_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        mce_pkg::t_char directed_set [23];
        directed_set = '{mce_pkg::CH_UC_A, mce_pkg::CH_UC_Z, mce_pkg::CH_LC_A,
                         mce_pkg::CH_LC_Z, mce_pkg::CH_ZERO, mce_pkg::CH_NINE,
                         mce_pkg::CH_SPACE, mce_pkg::CH_PERIOD, mce_pkg::CH_COMMA,
                         mce_pkg::CH_QUEST, mce_pkg::CH_SLASH, mce_pkg::CH_APOS,
                         mce_pkg::CH_EXCL, 8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF, 8'h40, 8'h5B,
                         8'h60, 8'h7B, 8'h3A};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_set[k]) send_char(directed_set[k]);
        drain_units();

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = SEND_IDLE_PCT[phase];
            receiver_stall_pct = RECV_STALL_PCT[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) send_char(pick_char());
            drain_units();
        end

        repeat (HOLD_OFF) @(posedge i_clk);
        $display("covered %0d characters and %0d key units: letters in both cases, digits,",
            chars_sent, units_taken);
        $display("punctuation, unmapped codes, back-to-back and stalled handshakes");
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
